// ===== rtl/core/ogiq_pkg.sv =====
// ----------------------------------------------------------------------------
// ogiq_pkg: shared definitions for the guard insertion quantizer
// Register indexes, output format codes, default sizes and the quantizer
// configuration bundle.
// ----------------------------------------------------------------------------
package ogiq_pkg;

  // Default store depth in samples
  localparam int unsigned MAX_SYMBOL_DEF = 8192;

  // Field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned OUT_W    = 25;
  localparam int unsigned SYMLEN_W = 14;
  localparam int unsigned GUARD_W  = 12;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned LEVEL_W  = 15;
  localparam int unsigned FMT_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT        = 3'd4;

  // Output format codes; other codes give zero
  localparam logic [FMT_W-1:0] FMT_S8   = 3'd0;
  localparam logic [FMT_W-1:0] FMT_U8   = 3'd1;
  localparam logic [FMT_W-1:0] FMT_S16  = 3'd2;
  localparam logic [FMT_W-1:0] FMT_U16  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_WIDE = 3'd4;

  // Input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PULL  = 1'b1;

  // Output status codes
  localparam logic ST_SAMPLE   = 1'b0;
  localparam logic ST_REJECTED = 1'b1;

  // Reset values of the registers
  localparam logic [SYMLEN_W-1:0] SYMLEN_RST = 14'd2048;
  localparam logic [GUARD_W-1:0]  GUARD_RST  = 12'd512;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd256;
  localparam logic [LEVEL_W-1:0]  LEVEL_RST  = 15'd127;
  localparam logic [FMT_W-1:0]    FMT_RST    = FMT_S8;

  // Settings the quantizer needs
  typedef struct packed {
    logic [LEVEL_W-1:0] max_level;
    logic [FMT_W-1:0]   format;
  } quant_cfg_t;

endpackage

// ===== rtl/core/ogiq_ram.sv =====
// ----------------------------------------------------------------------------
// ogiq_ram: generic single-port RAM
// One write or one read per cycle, read data registered and held while the
// port is not enabled.
// ----------------------------------------------------------------------------
module ogiq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = ogiq_pkg::MAX_SYMBOL_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write or read one entry
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ogiq_quant.sv =====
// ----------------------------------------------------------------------------
// ogiq_quant: gain scaling and output quantization of one sample part
// Registers the Q1.15 x Q8.8 product, then combinationally clamps (8- and
// 16-bit formats), rounds or truncates and wraps it to the selected format.
// ----------------------------------------------------------------------------
module ogiq_quant (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [ogiq_pkg::SAMPLE_W-1:0]  sample,
  input  logic        [ogiq_pkg::GAIN_W-1:0]    gain,
  input  ogiq_pkg::quant_cfg_t                  qcfg,
  output logic signed [ogiq_pkg::OUT_W-1:0]     value
);

  logic signed [32:0] prod_full;
  logic signed [31:0] prod_r;
  logic signed [31:0] prod_nxt;

  logic signed [39:0] pe;
  logic signed [39:0] lim;
  logic signed [39:0] pc;
  logic        [39:0] mag;
  logic        [39:0] sh;
  logic        [39:0] tz;
  logic signed [39:0] q;
  logic signed [39:0] qc;
  logic        [39:0] v;
  logic        [39:0] mag4;
  logic        [39:0] sh4;
  logic        [39:0] t4;

  // Multiply by the unsigned gain; the product fits 32 bits
  assign prod_full = sample * $signed({1'b0, gain});
  assign prod_nxt  = prod_full[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  // Quantize the held product
  always_comb begin
    pe  = {{8{prod_r[31]}}, prod_r};
    lim = $signed({2'b00, qcfg.max_level, 23'd0});

    // Signed formats: clamp to +-level, truncate toward zero
    if (pe > lim) begin
      pc = lim;
    end else if (pe < -lim) begin
      pc = -lim;
    end else begin
      pc = pe;
    end
    mag = pc[39] ? 40'(-pc) : 40'(pc);
    sh  = mag >> 23;
    tz  = pc[39] ? 40'(-sh) : sh;

    // Unsigned formats: add half a level, clamp to 0..level, floor
    q = pe + $signed({3'b000, qcfg.max_level, 22'd0});
    if (q > lim) begin
      qc = lim;
    end else if (q[39]) begin
      qc = '0;
    end else begin
      qc = q;
    end
    v = 40'(qc) >> 23;

    // Wide format: keep 8 fraction bits, truncate toward zero
    mag4 = pe[39] ? 40'(-pe) : 40'(pe);
    sh4  = mag4 >> 15;
    t4   = pe[39] ? 40'(-sh4) : sh4;

    case (qcfg.format)
      ogiq_pkg::FMT_S8:   value = {{17{tz[7]}}, tz[7:0]};
      ogiq_pkg::FMT_U8:   value = {17'd0, v[7:0]};
      ogiq_pkg::FMT_S16:  value = {{9{tz[15]}}, tz[15:0]};
      ogiq_pkg::FMT_U16:  value = {9'd0, v[15:0]};
      ogiq_pkg::FMT_WIDE: value = t4[ogiq_pkg::OUT_W-1:0];
      default:            value = '0;
    endcase
  end

endmodule

// ===== rtl/core/ofdm_guard_insert_quantizer_top.sv =====
// ----------------------------------------------------------------------------
// ofdm_guard_insert_quantizer_top: cyclic prefix insertion with quantization
// Loads one OFDM symbol into a sample store, then plays out the cyclic
// prefix and the symbol, scaled by a Q8.8 gain and quantized per format.
// ----------------------------------------------------------------------------
// The block takes one word per clock on its input stream while out_tready
// allows it; each result passes the store read, product and output registers.
// The single-port sample store allows one write or one read per cycle, which
// sets the one-word-per-clock figure. A word with tuser 0 writes a sample;
// once symbol_length samples are held the block drains, and words with tuser
// 1 pull the last guard_length samples followed by the whole symbol, with
// tlast on the final one. Writes while draining come back with status 1 and
// zero data; pulls while loading give no result. The store needs no clearing
// pass after reset. Configuration writes are always accepted and act at once;
// issue them only while no result is in flight.
// ----------------------------------------------------------------------------
module ofdm_guard_insert_quantizer_top #(
  parameter int unsigned MAX_SYMBOL = ogiq_pkg::MAX_SYMBOL_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [31:0]                         in_tdata,  // sample_real, sample_imag
  input  logic                                in_tuser,  // operation
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [55:0]                         out_tdata, // out_real, out_imag, zero fill
  output logic                                out_tlast,
  output logic                                out_tuser, // status
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ogiq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ogiq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned AW = $clog2(MAX_SYMBOL);
  localparam int unsigned CW = $clog2(MAX_SYMBOL + 1);
  localparam int unsigned RW = $clog2(2 * MAX_SYMBOL);
  localparam int unsigned LW = ((CW > ogiq_pkg::SYMLEN_W) ? CW : ogiq_pkg::SYMLEN_W) + 1;
  localparam int unsigned XW = RW + 1;

  // Configuration registers
  logic [ogiq_pkg::SYMLEN_W-1:0] sym_len_r;
  logic [ogiq_pkg::GUARD_W-1:0]  guard_r;
  logic [ogiq_pkg::GAIN_W-1:0]   gain_r;
  logic [ogiq_pkg::LEVEL_W-1:0]  max_level_r;
  logic [ogiq_pkg::FMT_W-1:0]    format_r;

  // Sequencing state
  logic          draining_r, draining_nxt;
  logic [CW-1:0] wc_r, wc_nxt;
  logic [RW-1:0] rc_r, rc_nxt;

  // Pipeline control
  logic v1_r, v1_nxt, rej1_r, rej1_nxt, last1_r, last1_nxt;
  logic v2_r, rej2_r, last2_r;
  logic out_valid_r, out_rej_r, out_last_r;
  logic signed [ogiq_pkg::OUT_W-1:0] out_real_r, out_imag_r;

  logic adv, acc, op_pull;
  logic [CW-1:0] n_eff, g_eff;
  logic [XW-1:0] idx, fin_lhs, fin_rhs;
  logic          fin;
  logic [CW-1:0] wc_inc;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_rdata;
  logic signed [ogiq_pkg::OUT_W-1:0] q_real, q_imag;
  ogiq_pkg::quant_cfg_t qcfg;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;
  assign op_pull   = (in_tuser == ogiq_pkg::OP_PULL);
  assign cfg_ready = 1'b1;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_len_r   <= ogiq_pkg::SYMLEN_RST;
      guard_r     <= ogiq_pkg::GUARD_RST;
      gain_r      <= ogiq_pkg::GAIN_RST;
      max_level_r <= ogiq_pkg::LEVEL_RST;
      format_r    <= ogiq_pkg::FMT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ogiq_pkg::REG_SYMBOL_LENGTH: sym_len_r   <= cfg_data[ogiq_pkg::SYMLEN_W-1:0];
        ogiq_pkg::REG_GUARD_LENGTH:  guard_r     <= cfg_data[ogiq_pkg::GUARD_W-1:0];
        ogiq_pkg::REG_GAIN:          gain_r      <= cfg_data[ogiq_pkg::GAIN_W-1:0];
        ogiq_pkg::REG_MAX_LEVEL:     max_level_r <= cfg_data[ogiq_pkg::LEVEL_W-1:0];
        ogiq_pkg::REG_FORMAT:        format_r    <= cfg_data[ogiq_pkg::FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // Limit symbol and guard lengths
  always_comb begin
    if (sym_len_r == '0) begin
      n_eff = CW'(1);
    end else if (LW'(sym_len_r) > LW'(MAX_SYMBOL)) begin
      n_eff = CW'(MAX_SYMBOL);
    end else begin
      n_eff = CW'(sym_len_r);
    end
    if (LW'(guard_r) > LW'(n_eff)) begin
      g_eff = n_eff;
    end else begin
      g_eff = CW'(guard_r);
    end
  end

  // Pick the store address, advance counters, classify the word
  always_comb begin
    draining_nxt = draining_r;
    wc_nxt       = wc_r;
    rc_nxt       = rc_r;
    v1_nxt       = 1'b0;
    rej1_nxt     = ogiq_pkg::ST_SAMPLE;
    last1_nxt    = 1'b0;
    ram_we       = 1'b0;
    wc_inc       = wc_r + CW'(1);

    // Prefix reads the tail, then the symbol from its start
    if (XW'(rc_r) < XW'(g_eff)) begin
      idx = XW'(n_eff) - XW'(g_eff) + XW'(rc_r);
    end else begin
      idx = XW'(rc_r) - XW'(g_eff);
    end
    if (idx >= XW'(n_eff)) begin
      idx = XW'(n_eff) - XW'(1);
    end
    fin_lhs = XW'(rc_r) + XW'(1);
    fin_rhs = XW'(g_eff) + XW'(n_eff);
    fin     = (fin_lhs >= fin_rhs);

    ram_addr = draining_r ? idx[AW-1:0] : wc_r[AW-1:0];

    if (acc) begin
      if (!op_pull) begin
        if (draining_r) begin
          v1_nxt   = 1'b1;
          rej1_nxt = ogiq_pkg::ST_REJECTED;
        end else begin
          ram_we = (wc_r < CW'(MAX_SYMBOL));
          wc_nxt = wc_inc;
          if (wc_inc >= n_eff) begin
            draining_nxt = 1'b1;
            rc_nxt       = '0;
          end
        end
      end else if (draining_r) begin
        v1_nxt    = 1'b1;
        last1_nxt = fin;
        if (fin) begin
          draining_nxt = 1'b0;
          wc_nxt       = '0;
          rc_nxt       = '0;
        end else begin
          rc_nxt = rc_r + RW'(1);
        end
      end
    end
  end

  // Hold the sequencing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r <= 1'b0;
      wc_r       <= '0;
      rc_r       <= '0;
    end else begin
      draining_r <= draining_nxt;
      wc_r       <= wc_nxt;
      rc_r       <= rc_nxt;
    end
  end

  // Sample store
  ogiq_ram #(
    .WIDTH (32),
    .DEPTH (MAX_SYMBOL)
  ) u_store (
    .clk   (clk),
    .en    (adv),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_tdata),
    .rdata (ram_rdata)
  );

  assign qcfg.max_level = max_level_r;
  assign qcfg.format    = format_r;

  // Scale and quantize both parts
  ogiq_quant u_quant_real (
    .clk    (clk),
    .en     (adv),
    .sample ($signed(ram_rdata[15:0])),
    .gain   (gain_r),
    .qcfg   (qcfg),
    .value  (q_real)
  );

  ogiq_quant u_quant_imag (
    .clk    (clk),
    .en     (adv),
    .sample ($signed(ram_rdata[31:16])),
    .gain   (gain_r),
    .qcfg   (qcfg),
    .value  (q_imag)
  );

  // Advance the pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= v1_nxt;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // Advance the pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      rej1_r     <= rej1_nxt;
      last1_r    <= last1_nxt;
      rej2_r     <= rej1_r;
      last2_r    <= last1_r;
      out_rej_r  <= rej2_r;
      out_last_r <= last2_r;
      out_real_r <= rej2_r ? '0 : q_real;
      out_imag_r <= rej2_r ? '0 : q_imag;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_imag_r, out_real_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_rej_r;

  // A rejected write carries zero data and never ends a symbol
  a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ogiq_pkg::ST_REJECTED) |-> (out_tdata == '0 && !out_tlast))
    else $error("rejected word with data or last");

  // Draining ends only on an accepted pull
  a_drain_end : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(draining_r) |-> $past(acc && op_pull))
    else $error("draining ended without a pull");

  // Loading ends only on an accepted write, with the read count cleared
  a_load_end : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(draining_r) |-> (rc_r == '0 && $past(acc && !op_pull)))
    else $error("draining started without a write");

  // The write count never runs past the store
  a_wc_range : assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= CW'(MAX_SYMBOL))
    else $error("write count beyond store depth");

endmodule
